[design/positional_list_engine_macros.svh]
// Assertion macros used by the positional list engine top level.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising clock edge outside reset.
`define PLE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define PLE_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PLE_ASSERT(lbl, clk, rst_n, prop, msg)

`define PLE_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[design/ple_pkg.sv]
// Package with types, constants and opcodes of the positional list engine.
package ple_pkg;

	localparam int OP_W       = 3;
	localparam int POS_W      = 5;
	localparam int VAL_W      = 32;
	localparam int CNT_OUT_W  = 5;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
	localparam logic [OP_W-1:0] OP_READ    = 3'd2;
	localparam logic [OP_W-1:0] OP_REPLACE = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                 ok;
		logic [VAL_W-1:0]     data;
		logic [CNT_OUT_W-1:0] count;
	} rsp_t;

	// Update command from the decoder to the row of list cells.
	typedef struct packed {
		logic             insert;
		logic             remove;
		logic             replace;
		logic [POS_W-1:0] pos0;
	} cmd_t;

endpackage

[design/positional_list_engine.sv]
// Top level of the positional list engine: request register, decode, result register.
//
//  channel   direction  handshake          payload
//  request   in         start, busy        req (opcode, position, value)
//  result    out        done               rsp (ok, data, count)
//
// One item is taken every cycle; busy stays low.
// Each item passes the request register, then the result register.
// All list cells shift in parallel in the cycle the item leaves the request register.
// Reset clears the entry count and the valid flags; entry contents are not reset.
// The receiver cannot stall, so no result is ever held back.
`include "positional_list_engine_macros.svh"

module positional_list_engine #(
	parameter int DEPTH      = ple_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ple_pkg::req_t req,
	output logic          done,
	output ple_pkg::rsp_t rsp
);
	import ple_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	logic                  valid_s1;
	req_t                  req_s1;
	logic [CNT_W-1:0]      count_q;
	logic                  done_q;
	rsp_t                  rsp_q;

	cmd_t                  cmd;
	logic [DATA_WIDTH-1:0] rd_data;
	logic [DATA_WIDTH-1:0] wdata;
	logic [CW-1:0]         pos_x;
	logic [CW-1:0]         cnt_x;
	logic                  in_list;
	logic                  ins_ok;
	logic                  ok;
	logic                  ret_data;
	logic                  clr;
	logic [CNT_W-1:0]      count_d;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	assign pos_x   = CW'(req_s1.position);
	assign cnt_x   = CW'(count_q);
	assign in_list = (req_s1.position != '0) && (pos_x <= cnt_x);
	assign ins_ok  = (req_s1.position != '0) && (pos_x <= cnt_x + CW'(1))
		&& (cnt_x < CW'(DEPTH));

	always_comb begin
		cmd.insert  = 1'b0;
		cmd.remove  = 1'b0;
		cmd.replace = 1'b0;
		cmd.pos0    = req_s1.position - POS_W'(1);
		ok          = 1'b0;
		ret_data    = 1'b0;
		clr         = 1'b0;
		count_d     = count_q;
		unique case (req_s1.opcode)
			OP_INSERT: begin
				ok         = ins_ok;
				cmd.insert = valid_s1 && ins_ok;
				if (ins_ok) count_d = count_q + CNT_W'(1);
			end
			OP_REMOVE: begin
				ok         = in_list;
				cmd.remove = valid_s1 && in_list;
				if (in_list) count_d = count_q - CNT_W'(1);
			end
			OP_READ: begin
				ok       = in_list;
				ret_data = in_list;
			end
			OP_REPLACE: begin
				ok          = in_list;
				ret_data    = in_list;
				cmd.replace = valid_s1 && in_list;
			end
			OP_CLEAR: begin
				ok      = 1'b1;
				clr     = 1'b1;
				count_d = '0;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	assign wdata = DATA_WIDTH'(req_s1.value);

	ple_list #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_list (
		.clk     (clk),
		.cmd     (cmd),
		.wdata   (wdata),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q.ok    <= ok;
			rsp_q.data  <= ret_data ? VAL_W'(rd_data) : '0;
			rsp_q.count <= CNT_OUT_W'(count_d);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`PLE_ASSERT(a_done_follows_item, clk, arst_n, done_q |-> $past(valid_s1), "result without an item")
	`PLE_NEVER(a_count_in_range, clk, arst_n, count_q > CNT_W'(DEPTH), "entry count above depth")
	`PLE_ASSERT(a_insert_counts, clk, arst_n, (valid_s1 && cmd.insert) |=> (count_q == $past(count_q) + CNT_W'(1)), "insert did not raise count")
	`PLE_NEVER(a_fail_no_data, clk, arst_n, done_q && !rsp_q.ok && (rsp_q.data != '0), "failed item returned data")
	`PLE_ASSERT(a_one_update, clk, arst_n, $onehot0({cmd.insert, cmd.remove, cmd.replace, valid_s1 && clr}), "more than one list update")

endmodule

[design/ple_list.sv]
// Row of list cells that shift in parallel on insert and remove, and take a new value on replace.
module ple_list #(
	parameter int DEPTH      = ple_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  ple_pkg::cmd_t         cmd,
	input  logic [DATA_WIDTH-1:0] wdata,
	output logic [DATA_WIDTH-1:0] rd_data
);
	import ple_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;

	logic [DATA_WIDTH-1:0] cells_q [DEPTH];
	logic [IDX_W-1:0]      rd_idx;

	// The decoder only uses the read data for positions inside the list, so truncation is safe.
	assign rd_idx  = IDX_W'(cmd.pos0);
	assign rd_data = cells_q[rd_idx];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  at_pos;
		logic                  past_pos;
		logic [DATA_WIDTH-1:0] below;
		logic [DATA_WIDTH-1:0] above;

		assign at_pos   = (IW'(i) == IW'(cmd.pos0));
		assign past_pos = (IW'(i) > IW'(cmd.pos0));

		if (i == 0) begin : g_first
			assign below = cells_q[i];
		end else begin : g_below
			assign below = cells_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign above = cells_q[i];
		end else begin : g_above
			assign above = cells_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.insert && past_pos) begin
				cells_q[i] <= below;
			end else if ((cmd.insert || cmd.replace) && at_pos) begin
				cells_q[i] <= wdata;
			end else if (cmd.remove && (at_pos || past_pos)) begin
				cells_q[i] <= above;
			end
		end
	end

endmodule
